// ===== sv/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, field widths and constants of the lidar scan packet parser.
// ----------------------------------------------------------------------------
package lsp_pkg;

    // Field widths of the byte and result channels and of the parser registers
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int ANGLE_W    = 17;
    localparam int DIST_W     = 16;
    localparam int INTEN_W    = 8;
    localparam int PNUM_W     = 4;
    localparam int STEP_W     = 10;
    localparam int TURN_W     = 17;
    localparam int START_W    = 16;
    localparam int ACC_W      = 18;
    localparam int COUNT_W    = 5;

    // Defaults for the top-level parameters
    localparam int PACKET_BYTES_DEF = 47;
    localparam int MAX_POINTS_DEF   = 12;

    // Packet framing
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h54;
    localparam int POS_COUNT     = 1;
    localparam int POS_ANGLE_LO  = 4;
    localparam int POS_ANGLE_HI  = 5;
    localparam int POS_FIRST_PT  = 6;
    localparam int BYTES_PER_PT  = 3;
    localparam int WRAP_TURN     = 36000;

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_RESET = 10'd80;
    localparam logic [TURN_W-1:0] TURN_RESET = 17'd36000;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_TURN  = 1'b1;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_POINT   = 2'd0,
        KIND_SCAN    = 2'd1,
        KIND_DROPPED = 2'd2
    } t_result_kind;

    // Phase of a byte within one point record
    typedef enum logic [1:0] {
        PH_DIST_LO = 2'd0,
        PH_DIST_HI = 2'd1,
        PH_INTEN   = 2'd2
    } t_point_phase;

endpackage

// ===== sv/lsp_byte_if.sv =====
// ----------------------------------------------------------------------------
// lsp_byte_if
// Valid/ready channel carrying one received byte per request.
// ----------------------------------------------------------------------------
interface lsp_byte_if;
    logic                          valid;
    logic                          ready;
    logic [lsp_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/lsp_result_if.sv =====
// ----------------------------------------------------------------------------
// lsp_result_if
// Valid/ready channel carrying one parser result per request.
// ----------------------------------------------------------------------------
interface lsp_result_if;
    logic                          valid;
    logic                          ready;
    logic [lsp_pkg::KIND_W-1:0]    result_kind;
    logic [lsp_pkg::ANGLE_W-1:0]   point_angle;
    logic [lsp_pkg::DIST_W-1:0]    point_distance;
    logic [lsp_pkg::INTEN_W-1:0]   point_intensity;
    logic [lsp_pkg::PNUM_W-1:0]    point_number;
    logic                          last_of_packet;

    modport source (output valid, output result_kind, output point_angle,
                    output point_distance, output point_intensity,
                    output point_number, output last_of_packet, input ready);
    modport sink   (input valid, input result_kind, input point_angle,
                    input point_distance, input point_intensity,
                    input point_number, input last_of_packet, output ready);
endinterface

// ===== sv/lidar_scan_packet_parser.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_packet_parser
// Byte-stream parser for a rotating lidar: emits points, scan-complete
// markers and bad-count drop notices.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte_if   - one lidar byte per request (valid/ready).
//   o_result_if - at most one result per accepted byte: a point, a
//                 scan-complete marker or a dropped-packet notice.
//   i_cfg_*     - write port for angle_step (index 0) and full_turn (1);
//                 write only while the parser is idle.
// Output: a result is registered and appears on o_result_if in the cycle
//   after the byte that causes it is accepted (the intensity byte for a
//   point, the high angle byte for a scan marker, the count byte for a drop).
// Throughput: one byte per cycle. The whole byte update sits between the
//   input handshake and one output register; the byte input stays ready
//   while that register is empty or is being taken in the same cycle.
// Stall: when the receiver holds ready low with a result waiting, byte
//   input stops until the result is taken; nothing is lost.
// Reset: synchronous, active low; byte input is held off during reset, the
//   parser hunts for the sync byte, the next packet counts as a first packet
//   and the registers return to angle_step 80 and full_turn 36000.
// ----------------------------------------------------------------------------
module lidar_scan_packet_parser #(
    parameter int PACKET_BYTES = lsp_pkg::PACKET_BYTES_DEF,
    parameter int MAX_POINTS   = lsp_pkg::MAX_POINTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lsp_byte_if.sink                         i_byte_if,
    lsp_result_if.source                     o_result_if,
    input  logic                             i_cfg_we,
    input  logic [lsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int POS_W   = $clog2(PACKET_BYTES);
    localparam int FIT_PTS = (PACKET_BYTES - lsp_pkg::POS_FIRST_PT) / lsp_pkg::BYTES_PER_PT;
    localparam int CAP     = (FIT_PTS < MAX_POINTS) ? FIT_PTS : MAX_POINTS;
    localparam logic [lsp_pkg::COUNT_W-1:0] CAP_V = lsp_pkg::COUNT_W'(CAP);

    // Configuration registers
    logic [lsp_pkg::STEP_W-1:0]  r_step;
    logic [lsp_pkg::TURN_W-1:0]  r_full_turn;

    // Parser state
    logic                          r_in_packet, n_in_packet;
    logic [POS_W-1:0]              r_pos, n_pos;
    logic [lsp_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [lsp_pkg::START_W-1:0]   r_start, n_start;
    logic [lsp_pkg::START_W-1:0]   r_prev, n_prev;
    logic [lsp_pkg::ACC_W-1:0]     r_acc, n_acc;
    logic                          r_first, n_first;
    logic                          r_discard, n_discard;
    logic [lsp_pkg::DIST_W-1:0]    r_dist, n_dist;
    logic [lsp_pkg::COUNT_W-1:0]   r_idx, n_idx;
    lsp_pkg::t_point_phase         r_phase, n_phase;

    // Result register
    logic                          r_out_valid, n_out_valid;
    lsp_pkg::t_result_kind         r_kind, n_kind;
    logic [lsp_pkg::ANGLE_W-1:0]   r_angle, n_angle;
    logic [lsp_pkg::DIST_W-1:0]    r_out_dist, n_out_dist;
    logic [lsp_pkg::INTEN_W-1:0]   r_inten, n_inten;
    logic [lsp_pkg::PNUM_W-1:0]    r_pnum, n_pnum;
    logic                          r_last, n_last;

    logic                          w_take;
    logic                          w_emit;
    logic [lsp_pkg::BYTE_W-1:0]    w_b;
    logic [POS_W:0]                w_pos_inc;
    logic [lsp_pkg::START_W-1:0]   w_start_full;
    logic signed [lsp_pkg::ACC_W-1:0] w_diff;
    logic signed [lsp_pkg::ACC_W-1:0] w_wrap;
    logic [lsp_pkg::START_W-1:0]   w_delta;
    logic [lsp_pkg::ACC_W-1:0]     w_sum;
    logic [lsp_pkg::PNUM_W+lsp_pkg::STEP_W-1:0] w_offset;

    // Handshake: input flows out of reset while the result slot is free or draining
    assign i_byte_if.ready = i_rst_n && (!r_out_valid || o_result_if.ready);
    assign w_take          = i_byte_if.valid && i_byte_if.ready;
    assign w_b             = i_byte_if.rx_byte;

    assign o_result_if.valid           = r_out_valid;
    assign o_result_if.result_kind     = r_kind;
    assign o_result_if.point_angle     = r_angle;
    assign o_result_if.point_distance  = r_out_dist;
    assign o_result_if.point_intensity = r_inten;
    assign o_result_if.point_number    = r_pnum;
    assign o_result_if.last_of_packet  = r_last;

    // Angle and turn arithmetic
    assign w_pos_inc    = {1'b0, r_pos} + (POS_W+1)'(1);
    assign w_start_full = {w_b, r_start[lsp_pkg::BYTE_W-1:0]};
    assign w_diff       = signed'({2'b00, w_start_full}) - signed'({2'b00, r_prev});
    always_comb begin
        w_wrap = w_diff;
        if (w_diff < 0) begin
            w_wrap = w_diff + lsp_pkg::ACC_W'(lsp_pkg::WRAP_TURN);
        end
    end
    assign w_delta  = (w_wrap < 0) ? '0 : w_wrap[lsp_pkg::START_W-1:0];
    assign w_sum    = r_acc + {2'b00, w_delta};
    assign w_offset = r_idx[lsp_pkg::PNUM_W-1:0] * r_step;

    // Next-state logic for one accepted byte
    always_comb begin
        n_in_packet = r_in_packet;
        n_pos       = r_pos;
        n_count     = r_count;
        n_start     = r_start;
        n_prev      = r_prev;
        n_acc       = r_acc;
        n_first     = r_first;
        n_discard   = r_discard;
        n_dist      = r_dist;
        n_idx       = r_idx;
        n_phase     = r_phase;
        w_emit      = 1'b0;
        n_kind      = lsp_pkg::KIND_POINT;
        n_angle     = '0;
        n_out_dist  = '0;
        n_inten     = '0;
        n_pnum      = '0;
        n_last      = 1'b0;

        if (w_take) begin
            if (!r_in_packet) begin
                // Hunting for sync
                if (w_b == lsp_pkg::SYNC_BYTE) begin
                    n_in_packet = 1'b1;
                    n_pos       = POS_W'(1);
                    n_discard   = 1'b0;
                    n_count     = '0;
                    n_idx       = '0;
                    n_phase     = lsp_pkg::PH_DIST_LO;
                end
            end else begin
                if (r_pos == POS_W'(lsp_pkg::POS_COUNT)) begin
                    // Point count, drop when over capacity
                    n_count = w_b[lsp_pkg::COUNT_W-1:0];
                    if (w_b[lsp_pkg::COUNT_W-1:0] > CAP_V) begin
                        n_discard = 1'b1;
                        w_emit    = 1'b1;
                        n_kind    = lsp_pkg::KIND_DROPPED;
                    end
                end else if (r_pos == POS_W'(lsp_pkg::POS_ANGLE_LO)) begin
                    n_start = {8'h00, w_b};
                end else if (r_pos == POS_W'(lsp_pkg::POS_ANGLE_HI)) begin
                    // Start angle complete: update turn accumulator
                    n_start = w_start_full;
                    if (!r_discard) begin
                        if (r_first) begin
                            n_first = 1'b0;
                            n_prev  = w_start_full;
                        end else if (w_sum >= {1'b0, r_full_turn}) begin
                            w_emit    = 1'b1;
                            n_kind    = lsp_pkg::KIND_SCAN;
                            n_acc     = '0;
                            n_first   = 1'b1;
                            n_discard = 1'b1;
                        end else begin
                            n_acc  = w_sum;
                            n_prev = w_start_full;
                        end
                    end
                end else if (r_pos >= POS_W'(lsp_pkg::POS_FIRST_PT)) begin
                    // Point bytes
                    if (!r_discard && (r_idx < r_count)) begin
                        case (r_phase)
                            lsp_pkg::PH_DIST_LO: n_dist = {8'h00, w_b};
                            lsp_pkg::PH_DIST_HI: n_dist = {w_b, r_dist[lsp_pkg::BYTE_W-1:0]};
                            lsp_pkg::PH_INTEN: begin
                                w_emit     = 1'b1;
                                n_kind     = lsp_pkg::KIND_POINT;
                                n_angle    = {1'b0, r_start}
                                           + lsp_pkg::ANGLE_W'(w_offset);
                                n_out_dist = r_dist;
                                n_inten    = w_b;
                                n_pnum     = r_idx[lsp_pkg::PNUM_W-1:0];
                                n_last     = (r_idx + lsp_pkg::COUNT_W'(1)) == r_count;
                            end
                            default: n_dist = r_dist;
                        endcase
                    end
                    case (r_phase)
                        lsp_pkg::PH_DIST_LO: n_phase = lsp_pkg::PH_DIST_HI;
                        lsp_pkg::PH_DIST_HI: n_phase = lsp_pkg::PH_INTEN;
                        default: begin
                            n_phase = lsp_pkg::PH_DIST_LO;
                            n_idx   = r_idx + lsp_pkg::COUNT_W'(1);
                        end
                    endcase
                end

                // Packet end
                if (w_pos_inc >= (POS_W+1)'(PACKET_BYTES)) begin
                    n_in_packet = 1'b0;
                    n_pos       = '0;
                end else begin
                    n_pos = w_pos_inc[POS_W-1:0];
                end
            end
        end
    end

    // Result slot occupancy
    always_comb begin
        n_out_valid = r_out_valid && !o_result_if.ready;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= lsp_pkg::STEP_RESET;
            r_full_turn <= lsp_pkg::TURN_RESET;
            r_in_packet <= 1'b0;
            r_pos       <= '0;
            r_count     <= '0;
            r_acc       <= '0;
            r_first     <= 1'b1;
            r_discard   <= 1'b0;
            r_idx       <= '0;
            r_phase     <= lsp_pkg::PH_DIST_LO;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lsp_pkg::CFG_ANGLE_STEP: r_step <= i_cfg_data[lsp_pkg::STEP_W-1:0];
                    lsp_pkg::CFG_FULL_TURN:  r_full_turn <= i_cfg_data[lsp_pkg::TURN_W-1:0];
                    default: r_step <= r_step;
                endcase
            end
            r_in_packet <= n_in_packet;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_first     <= n_first;
            r_discard   <= n_discard;
            r_idx       <= n_idx;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_prev  <= n_prev;
        r_dist  <= n_dist;
        if (w_emit) begin
            r_kind     <= n_kind;
            r_angle    <= n_angle;
            r_out_dist <= n_out_dist;
            r_inten    <= n_inten;
            r_pnum     <= n_pnum;
            r_last     <= n_last;
        end
    end

endmodule
